FILE: rtl/igm_pkg.sv
// Shared types and constants for the input event to gesture mapper.
package igm_pkg;

    localparam int DEV_W       = 2;
    localparam int TYPE_W      = 16;
    localparam int CODE_W      = 16;
    localparam int VALUE_W     = 32;
    localparam int KIND_W      = 4;
    localparam int SIZE_W      = 13;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = SIZE_W;

    localparam logic [DEV_W-1:0] DEV_KEYPAD = 2'd0;
    localparam logic [DEV_W-1:0] DEV_GPIO   = 2'd1;
    localparam logic [DEV_W-1:0] DEV_TOUCH  = 2'd2;

    localparam logic [TYPE_W-1:0] TYPE_SYN = 16'h0000;
    localparam logic [TYPE_W-1:0] TYPE_KEY = 16'h0001;
    localparam logic [TYPE_W-1:0] TYPE_ABS = 16'h0003;

    localparam logic [CODE_W-1:0] CODE_NEXT    = 16'd407;
    localparam logic [CODE_W-1:0] CODE_PREV    = 16'd412;
    localparam logic [CODE_W-1:0] CODE_MENU    = 16'd139;
    localparam logic [CODE_W-1:0] CODE_BACK    = 16'd158;
    localparam logic [CODE_W-1:0] CODE_HOME    = 16'd102;
    localparam logic [CODE_W-1:0] CODE_POWER   = 16'd116;
    localparam logic [CODE_W-1:0] CODE_CONTACT = 16'd330;
    localparam logic [CODE_W-1:0] CODE_ABS_X   = 16'd0;
    localparam logic [CODE_W-1:0] CODE_ABS_Y   = 16'd1;
    localparam logic [CODE_W-1:0] CODE_SYN_REPORT = 16'd0;

    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

    localparam logic [SIZE_W-1:0] SCREEN_WIDTH_RESET  = 13'd600;
    localparam logic [SIZE_W-1:0] SCREEN_HEIGHT_RESET = 13'd800;

    typedef enum logic [KIND_W-1:0] {
        EV_NEXT     = 4'd0,
        EV_PREV     = 4'd1,
        EV_MENU     = 4'd2,
        EV_BACK     = 4'd3,
        EV_HOME     = 4'd4,
        EV_PWR_DOWN = 4'd5,
        EV_PWR_UP   = 4'd6,
        EV_T_DOWN   = 4'd7,
        EV_T_MOVE   = 4'd8,
        EV_T_UP     = 4'd9
    } evt_kind_t;

endpackage

FILE: rtl/igm_if.sv
// Valid/ready channel interfaces for input records and output events.
interface igm_rec_if;
    import igm_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [DEV_W-1:0]          source_dev;
    logic [TYPE_W-1:0]         rec_type;
    logic [CODE_W-1:0]         rec_code;
    logic signed [VALUE_W-1:0] rec_value;

    modport source (output valid, source_dev, rec_type, rec_code, rec_value, input ready);
    modport sink   (input valid, source_dev, rec_type, rec_code, rec_value, output ready);
endinterface

interface igm_evt_if #(
    parameter int COORD_BITS = 12
);
    import igm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [KIND_W-1:0]     event_kind;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic [DEV_W-1:0]      origin_dev;

    modport source (output valid, event_kind, pos_x, pos_y, origin_dev, input ready);
    modport sink   (input valid, event_kind, pos_x, pos_y, origin_dev, output ready);
endinterface

FILE: rtl/igm_clamp.sv
// Clamps a signed raw coordinate to 0 .. size-1, capped at the coordinate range.
module igm_clamp #(
    parameter int COORD_BITS = 12
) (
    input  logic signed [igm_pkg::VALUE_W-1:0] raw,
    input  logic [igm_pkg::SIZE_W-1:0]         size,
    output logic [COORD_BITS-1:0]              coord
);
    import igm_pkg::*;

    localparam int LW = (COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W;
    localparam logic [LW-1:0] COORD_MASK = LW'((1 << COORD_BITS) - 1);

    logic [SIZE_W-1:0] lim;
    logic [LW-1:0]     lim_w;
    logic [LW-1:0]     cap;
    logic [VALUE_W-1:0] cap_ext;

    always_comb
    begin
        lim     = (size == '0) ? '0 : size - SIZE_W'(1);
        lim_w   = LW'(lim);
        cap     = (lim_w > COORD_MASK) ? COORD_MASK : lim_w;
        cap_ext = VALUE_W'(cap);
        if (raw[VALUE_W-1])
            coord = '0;
        else if (VALUE_W'(raw) > cap_ext)
            coord = cap[COORD_BITS-1:0];
        else
            coord = raw[COORD_BITS-1:0];
    end

endmodule

FILE: rtl/input_event_touch_gesture_mapper_core.sv
// Path: accepted record -> record register -> event word in the output register.
// Throughput: one record per cycle; the record register and the event register
// advance together whenever the event register is empty or being taken.
// Records that yield no event still pass through the record register.
// Reset: rst_n, async active low; clears valid bits, frame and gesture state,
// and loads screen size 600 x 800.
module input_event_touch_gesture_mapper_core #(
    parameter int COORD_BITS = 12
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [igm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [igm_pkg::CFG_DATA_W-1:0]   cfg_data,
    igm_rec_if.sink                          rec,
    igm_evt_if.source                        evt
);
    import igm_pkg::*;

    logic [SIZE_W-1:0] width_reg, height_reg;

    logic                      s1_valid_reg;
    logic [DEV_W-1:0]          s1_dev_reg;
    logic [TYPE_W-1:0]         s1_type_reg;
    logic [CODE_W-1:0]         s1_code_reg;
    logic signed [VALUE_W-1:0] s1_value_reg;
    logic                      s1_fire;

    logic signed [VALUE_W-1:0] frame_x_raw_reg, frame_x_raw_next;
    logic signed [VALUE_W-1:0] frame_y_raw_reg, frame_y_raw_next;
    logic                      frame_contact_reg, frame_contact_next;
    logic                      gesture_active_reg, gesture_active_next;
    logic [COORD_BITS-1:0]     latest_x_reg, latest_x_next;
    logic [COORD_BITS-1:0]     latest_y_reg, latest_y_next;
    logic [COORD_BITS-1:0]     emitted_x_reg, emitted_x_next;
    logic [COORD_BITS-1:0]     emitted_y_reg, emitted_y_next;

    logic                  out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]     out_kind_reg;
    logic [COORD_BITS-1:0] out_x_reg, out_y_reg;
    logic [DEV_W-1:0]      out_dev_reg;

    logic                  res_valid;
    evt_kind_t             res_kind;
    logic [COORD_BITS-1:0] res_x, res_y;
    logic [COORD_BITS-1:0] clamp_x, clamp_y;
    logic                  pressed;

    // config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SCREEN_WIDTH_RESET;
            height_reg <= SCREEN_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                REG_SCREEN_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // record register
    assign s1_fire   = s1_valid_reg && (!out_valid_reg || evt.ready);
    assign rec.ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (rec.ready)
            s1_valid_reg <= rec.valid;
    end

    always_ff @(posedge clk)
    begin
        if (rec.valid && rec.ready)
        begin
            s1_dev_reg   <= rec.source_dev;
            s1_type_reg  <= rec.rec_type;
            s1_code_reg  <= rec.rec_code;
            s1_value_reg <= rec.rec_value;
        end
    end

    igm_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_x (
        .raw   (frame_x_raw_reg),
        .size  (width_reg),
        .coord (clamp_x)
    );

    igm_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_y (
        .raw   (frame_y_raw_reg),
        .size  (height_reg),
        .coord (clamp_y)
    );

    assign pressed = |s1_value_reg;

    always_comb
    begin
        frame_x_raw_next    = frame_x_raw_reg;
        frame_y_raw_next    = frame_y_raw_reg;
        frame_contact_next  = frame_contact_reg;
        gesture_active_next = gesture_active_reg;
        latest_x_next       = latest_x_reg;
        latest_y_next       = latest_y_reg;
        emitted_x_next      = emitted_x_reg;
        emitted_y_next      = emitted_y_reg;
        res_valid           = 1'b0;
        res_kind            = EV_NEXT;
        res_x               = '0;
        res_y               = '0;

        if (s1_dev_reg == DEV_TOUCH)
        begin
            if (s1_type_reg == TYPE_ABS)
            begin
                if (s1_code_reg == CODE_ABS_X)
                    frame_x_raw_next = s1_value_reg;
                else if (s1_code_reg == CODE_ABS_Y)
                    frame_y_raw_next = s1_value_reg;
            end
            else if (s1_type_reg == TYPE_KEY && s1_code_reg == CODE_CONTACT)
            begin
                frame_contact_next = pressed;
            end
            else if (s1_type_reg == TYPE_SYN && s1_code_reg == CODE_SYN_REPORT)
            begin
                if (frame_contact_reg)
                begin
                    latest_x_next = clamp_x;
                    latest_y_next = clamp_y;
                    res_x         = clamp_x;
                    res_y         = clamp_y;
                    if (!gesture_active_reg)
                    begin
                        gesture_active_next = 1'b1;
                        emitted_x_next      = clamp_x;
                        emitted_y_next      = clamp_y;
                        res_valid           = 1'b1;
                        res_kind            = EV_T_DOWN;
                    end
                    else if (clamp_x != emitted_x_reg || clamp_y != emitted_y_reg)
                    begin
                        emitted_x_next = clamp_x;
                        emitted_y_next = clamp_y;
                        res_valid      = 1'b1;
                        res_kind       = EV_T_MOVE;
                    end
                end
                else if (gesture_active_reg)
                begin
                    gesture_active_next = 1'b0;
                    latest_x_next       = '0;
                    latest_y_next       = '0;
                    emitted_x_next      = '0;
                    emitted_y_next      = '0;
                    res_valid           = 1'b1;
                    res_kind            = EV_T_UP;
                    res_x               = latest_x_reg;
                    res_y               = latest_y_reg;
                end
            end
        end
        else if (s1_type_reg == TYPE_KEY)
        begin
            if (s1_dev_reg == DEV_KEYPAD)
            begin
                res_valid = pressed;
                case (s1_code_reg)
                    CODE_NEXT: res_kind = EV_NEXT;
                    CODE_PREV: res_kind = EV_PREV;
                    CODE_MENU: res_kind = EV_MENU;
                    CODE_BACK: res_kind = EV_BACK;
                    default:   res_valid = 1'b0;
                endcase
            end
            else if (s1_dev_reg == DEV_GPIO)
            begin
                if (s1_code_reg == CODE_HOME)
                begin
                    res_valid = pressed;
                    res_kind  = EV_HOME;
                end
                else if (s1_code_reg == CODE_POWER)
                begin
                    res_valid = 1'b1;
                    res_kind  = pressed ? EV_PWR_DOWN : EV_PWR_UP;
                end
            end
        end
    end

    // frame and gesture state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_x_raw_reg    <= '0;
            frame_y_raw_reg    <= '0;
            frame_contact_reg  <= 1'b0;
            gesture_active_reg <= 1'b0;
            latest_x_reg       <= '0;
            latest_y_reg       <= '0;
            emitted_x_reg      <= '0;
            emitted_y_reg      <= '0;
        end
        else if (s1_fire)
        begin
            frame_x_raw_reg    <= frame_x_raw_next;
            frame_y_raw_reg    <= frame_y_raw_next;
            frame_contact_reg  <= frame_contact_next;
            gesture_active_reg <= gesture_active_next;
            latest_x_reg       <= latest_x_next;
            latest_y_reg       <= latest_y_next;
            emitted_x_reg      <= emitted_x_next;
            emitted_y_reg      <= emitted_y_next;
        end
    end

    // event register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_fire)
            out_valid_next = res_valid;
        else if (evt.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && res_valid)
        begin
            out_kind_reg <= res_kind;
            out_x_reg    <= res_x;
            out_y_reg    <= res_y;
            out_dev_reg  <= s1_dev_reg;
        end
    end

    assign evt.valid      = out_valid_reg;
    assign evt.event_kind = out_kind_reg;
    assign evt.pos_x      = out_x_reg;
    assign evt.pos_y      = out_y_reg;
    assign evt.origin_dev = out_dev_reg;

endmodule
